// ===== sv/ipd_pkg.sv =====
// Shared types and constants for the isolated pixel detector.
// Used by the line buffer and the top level; depends on nothing.
package ipd_pkg;

    // Configuration port widths, fixed by the register map.
    localparam int CFG_DATA_W = 13;
    localparam int ROWS_CFG_W = 13;
    localparam int COLS_CFG_W = 11;

    // Register indexes on the configuration port.
    typedef enum logic [0:0] {
        CFG_IMAGE_ROWS = 1'b0,
        CFG_IMAGE_COLS = 1'b1
    } ipd_cfg_index_t;

    // Outputs of one line buffer: pixel one row back and the one after it.
    typedef struct packed {
        logic tail;     // delay of one full row
        logic pretail;  // delay of one row less one pixel
    } ipd_taps_t;

endpackage

// ===== sv/ipd_pixel_if.sv =====
// Pixel input channel: valid/ready handshake with a one-bit pixel.
// Stand-alone; no package dependency.
interface ipd_pixel_if;
    logic valid;
    logic ready;
    logic pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// ===== sv/ipd_result_if.sv =====
// Result channel: valid/ready handshake with the per-frame found bit.
// Stand-alone; no package dependency.
interface ipd_result_if;
    logic valid;
    logic ready;
    logic isolated_found;

    modport source (output valid, output isolated_found, input ready);
    modport sink   (input valid, input isolated_found, output ready);
endinterface

// ===== sv/ipd_cell.sv =====
// One storage cell of a line buffer: holds a pixel, takes either the
// neighbor's pixel or the incoming one. No package dependency.
module ipd_cell
(
    input  logic clk,
    input  logic shift_en,
    input  logic load,
    input  logic din,
    input  logic prev,
    output logic dout
);

    logic data_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            data_reg <= load ? din : prev;
        end
    end

    assign dout = data_reg;

endmodule

// ===== sv/ipd_line.sv =====
// Row line buffer built as a chain of ipd_cell; the entry point moves with
// the row length so the tail always lags by one row. Depends on ipd_pkg.
module ipd_line #(
    parameter int MAX_COLS = 1024
)
(
    input  logic                 clk,
    input  logic                 shift_en,
    input  logic [MAX_COLS-1:0]  entry_sel,
    input  logic                 din,
    output ipd_pkg::ipd_taps_t   taps
);
    import ipd_pkg::*;

    logic [MAX_COLS-1:0] cell_q;

    for (genvar i = 0; i < MAX_COLS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            ipd_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .load     (entry_sel[i]),
                .din      (din),
                .prev     (din),
                .dout     (cell_q[i])
            );
        end
        else
        begin : g_body
            ipd_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .load     (entry_sel[i]),
                .din      (din),
                .prev     (cell_q[i-1]),
                .dout     (cell_q[i])
            );
        end
    end

    assign taps.tail    = cell_q[MAX_COLS-1];
    assign taps.pretail = cell_q[MAX_COLS-2];

endmodule

// ===== sv/isolated_pixel_detector.sv =====
// Isolated pixel detector (4-connected), top level.
// Throughput: one pixel per cycle; a frame's last pixel stalls while the prior result waits.
// Latency: the frame result is registered and valid the cycle after the last pixel.
// Two cell-chain line buffers give the row-above taps; window checks are one level.
// Reset (rst_n, async, low): image size 1x1, frame position and found flag cleared.
module isolated_pixel_detector #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 4096
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    ipd_pixel_if.sink                       pixels,
    ipd_result_if.source                    results,
    input  logic                            wr_en,
    input  ipd_pkg::ipd_cfg_index_t         wr_index,
    input  logic [ipd_pkg::CFG_DATA_W-1:0]  wr_data
);
    import ipd_pkg::*;

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);

    // Frame geometry, stored as last index after clamping to 1..MAX.
    logic [COL_W-1:0]    cols_last_reg, cols_last_next;
    logic [ROW_W-1:0]    rows_last_reg, rows_last_next;
    logic [MAX_COLS-1:0] entry_sel_reg, entry_sel_next;

    // Raster position and sticky flag.
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             found_reg, found_next;

    // Short pixel history: one and two pixels back, one row plus one back.
    logic d1_reg, d2_reg, drow1_reg;

    // Output register.
    logic out_valid_reg, out_valid_next;
    logic out_found_reg, out_found_next;

    ipd_taps_t taps_a, taps_b;

    logic accept;
    logic last_col, last_row, frame_end;
    logic has_row1, has_row2, has_left, has_left2, has_right;
    logic iso_above, iso_prev, iso_cur, found_upd;

    logic [31:0] cfg_wide;

    // ---------------------------------------------------------------
    // Handshake: a non-final pixel always goes in; the final pixel of a
    // frame needs the output register free or draining this cycle.
    // ---------------------------------------------------------------
    assign last_col  = (col_reg == cols_last_reg);
    assign last_row  = (row_reg == rows_last_reg);
    assign frame_end = last_col && last_row;

    assign pixels.ready = !frame_end || !out_valid_reg || results.ready;
    assign accept       = pixels.valid && pixels.ready;

    // ---------------------------------------------------------------
    // Line buffers: A lags the stream by one row, B by two rows.
    // ---------------------------------------------------------------
    ipd_line #(.MAX_COLS(MAX_COLS)) u_line_a (
        .clk       (clk),
        .shift_en  (accept),
        .entry_sel (entry_sel_reg),
        .din       (pixels.pixel),
        .taps      (taps_a)
    );

    ipd_line #(.MAX_COLS(MAX_COLS)) u_line_b (
        .clk       (clk),
        .shift_en  (accept),
        .entry_sel (entry_sel_reg),
        .din       (taps_a.tail),
        .taps      (taps_b)
    );

    // ---------------------------------------------------------------
    // Neighborhood tests.
    // iso_above: centre is the pixel one row above the incoming one; the
    //   incoming pixel is its lower neighbor.
    // iso_prev:  on the last row, the previous pixel has no lower neighbor;
    //   the incoming pixel is its right neighbor.
    // iso_cur:   the very last pixel of the frame, tested on arrival.
    // ---------------------------------------------------------------
    assign has_row1  = (row_reg != '0);
    assign has_row2  = (row_reg > ROW_W'(1));
    assign has_left  = (col_reg != '0);
    assign has_left2 = (col_reg > COL_W'(1));
    assign has_right = !last_col;

    assign iso_above = has_row1 && taps_a.tail
                     && !(has_row2 && taps_b.tail)
                     && !(has_left && drow1_reg)
                     && !(has_right && taps_a.pretail)
                     && !pixels.pixel;

    assign iso_prev  = last_row && has_left && d1_reg
                     && !(has_left2 && d2_reg)
                     && !(has_row1 && drow1_reg)
                     && !pixels.pixel;

    assign iso_cur   = frame_end && pixels.pixel
                     && !(has_left && d1_reg)
                     && !(has_row1 && taps_a.tail);

    assign found_upd = found_reg || iso_above || iso_prev || iso_cur;

    // ---------------------------------------------------------------
    // Configuration decode: clamp to 1..MAX and store the last index;
    // the chain from the cell where a row enters to the tail is one row long.
    // ---------------------------------------------------------------
    always_comb
    begin
        cols_last_next = cols_last_reg;
        rows_last_next = rows_last_reg;
        cfg_wide       = 32'(wr_data);
        unique case (wr_index)
            CFG_IMAGE_ROWS:
            begin
                cfg_wide = 32'(wr_data[ROWS_CFG_W-1:0]);
                if (cfg_wide == 32'd0)
                    rows_last_next = '0;
                else if (cfg_wide > 32'(MAX_ROWS))
                    rows_last_next = ROW_W'(MAX_ROWS - 1);
                else
                    rows_last_next = ROW_W'(cfg_wide - 32'd1);
            end
            CFG_IMAGE_COLS:
            begin
                cfg_wide = 32'(wr_data[COLS_CFG_W-1:0]);
                if (cfg_wide == 32'd0)
                    cols_last_next = '0;
                else if (cfg_wide > 32'(MAX_COLS))
                    cols_last_next = COL_W'(MAX_COLS - 1);
                else
                    cols_last_next = COL_W'(cfg_wide - 32'd1);
            end
            default:
            begin
                cols_last_next = cols_last_reg;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < MAX_COLS; i++)
        begin
            entry_sel_next[i] = (COL_W'(MAX_COLS - 1 - i) == cols_last_next);
        end
    end

    // ---------------------------------------------------------------
    // Position, flag and result next state.
    // ---------------------------------------------------------------
    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;

        // drain the result once the sink takes it
        if (out_valid_reg && results.ready)
            out_valid_next = 1'b0;

        priority if (wr_en)
        begin
            // restart the frame; buffers are rewritten before being read
            col_next   = '0;
            row_next   = '0;
            found_next = 1'b0;
        end
        else if (accept)
        begin
            if (frame_end)
            begin
                col_next       = '0;
                row_next       = '0;
                found_next     = 1'b0;
                out_valid_next = 1'b1;
                out_found_next = found_upd;
            end
            else if (last_col)
            begin
                col_next   = '0;
                row_next   = row_reg + ROW_W'(1);
                found_next = found_upd;
            end
            else
            begin
                col_next   = col_reg + COL_W'(1);
                found_next = found_upd;
            end
        end
        else
        begin
            // hold position and flag while no pixel arrives
            found_next = found_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_last_reg <= '0;
            rows_last_reg <= '0;
            entry_sel_reg <= MAX_COLS'(1) << (MAX_COLS - 1);
            col_reg       <= '0;
            row_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                cols_last_reg <= cols_last_next;
                rows_last_reg <= rows_last_next;
                entry_sel_reg <= entry_sel_next;
            end
            col_reg       <= col_next;
            row_reg       <= row_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Pixel history and result payload: no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            d1_reg    <= pixels.pixel;
            d2_reg    <= d1_reg;
            drow1_reg <= taps_a.tail;
        end
        out_found_reg <= out_found_next;
    end

    assign results.valid          = out_valid_reg;
    assign results.isolated_found = out_found_reg;

endmodule

// ===== tb/isolated_pixel_checker.sv =====
// Checker for the isolated pixel detector: tracks register writes, predicts
// each frame verdict and compares it with the result channel.
// Depends on ipd_pkg, ipd_pixel_if and ipd_result_if.
module isolated_pixel_checker #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 4096
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    ipd_pixel_if                            pixels,
    ipd_result_if                           results,
    input  logic                            wr_en,
    input  ipd_pkg::ipd_cfg_index_t         wr_index,
    input  logic [ipd_pkg::CFG_DATA_W-1:0]  wr_data,
    output int                              pending_results,
    output int                              error_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import ipd_pkg::*;

    // Row two above the incoming one (rewritten in place) and the row just above.
    bit                    two_rows_up [MAX_COLS];
    bit                    one_row_up  [MAX_COLS];
    logic [ROWS_CFG_W-1:0] rows_reg;
    logic [COLS_CFG_W-1:0] cols_reg;
    int unsigned           frame_row;
    int unsigned           frame_col;
    bit                    frame_found;
    bit                    found_expected [$];

    function automatic int unsigned active_rows();
        if (rows_reg == '0)
            return 1;
        if (rows_reg > MAX_ROWS)
            return MAX_ROWS;
        return 32'(rows_reg);
    endfunction

    function automatic int unsigned active_cols();
        if (cols_reg == '0)
            return 1;
        if (cols_reg > MAX_COLS)
            return MAX_COLS;
        return 32'(cols_reg);
    endfunction

    function automatic void restart_frame();
        frame_row   = 0;
        frame_col   = 0;
        frame_found = 1'b0;
    endfunction

    // Neighbors outside the image arrive here as 0.
    function automatic void test_centre(bit centre, bit up, bit left, bit right, bit down);
        if (centre && !(up || left || right || down))
            frame_found = 1'b1;
    endfunction

    // Advance the frame by one pixel; return 1 when it closes the frame.
    function automatic bit take_pixel(input bit px, output bit found);
        int unsigned rows;
        int unsigned cols;
        int unsigned r;
        int unsigned c;
        bit          held;
        rows  = active_rows();
        cols  = active_cols();
        r     = frame_row;
        c     = frame_col;
        found = 1'b0;
        if (r >= rows || c >= cols)
        begin
            restart_frame();
            r = 0;
            c = 0;
        end
        // The pixel above the incoming one now has all its neighbors.
        if (r >= 1)
            test_centre(one_row_up[c],
                        (r >= 2) ? two_rows_up[c] : 1'b0,
                        (c > 0) ? one_row_up[c - 1] : 1'b0,
                        (c + 1 < cols) ? one_row_up[c + 1] : 1'b0,
                        px);
        two_rows_up[c] = px;
        if (c + 1 < cols)
        begin
            frame_col = c + 1;
            return 1'b0;
        end
        frame_col = 0;
        if (r + 1 < rows)
        begin
            for (int k = 0; k < cols; k++)
            begin
                held           = two_rows_up[k];
                two_rows_up[k] = one_row_up[k];
                one_row_up[k]  = held;
            end
            frame_row = r + 1;
            return 1'b0;
        end
        // Last row: no lower neighbors.
        for (int k = 0; k < cols; k++)
            test_centre(two_rows_up[k],
                        (r >= 1) ? one_row_up[k] : 1'b0,
                        (k > 0) ? two_rows_up[k - 1] : 1'b0,
                        (k + 1 < cols) ? two_rows_up[k + 1] : 1'b0,
                        1'b0);
        found = frame_found;
        restart_frame();
        return 1'b1;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bit found;
        bit want;
        if (!rst_n)
        begin
            foreach (two_rows_up[k])
            begin
                two_rows_up[k] = 1'b0;
                one_row_up[k]  = 1'b0;
            end
            rows_reg = ROWS_CFG_W'(1);
            cols_reg = COLS_CFG_W'(1);
            restart_frame();
            found_expected.delete();
            error_count = 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    CFG_IMAGE_ROWS: rows_reg = wr_data[ROWS_CFG_W-1:0];
                    CFG_IMAGE_COLS: cols_reg = wr_data[COLS_CFG_W-1:0];
                endcase
                restart_frame();
            end
            if (results.valid && results.ready)
            begin
                if (found_expected.size() == 0)
                    report_mismatch($sformatf("result isolated_found=%0b with no frame closed",
                                              results.isolated_found));
                else
                begin
                    want = found_expected.pop_front();
                    if (results.isolated_found !== want)
                        report_mismatch($sformatf("isolated_found=%0b, expected %0b",
                                                  results.isolated_found, want));
                end
            end
            if (pixels.valid && pixels.ready && take_pixel(pixels.pixel, found))
                found_expected.push_back(found);
        end
        pending_results = found_expected.size();
    end

endmodule

// ===== tb/isolated_pixel_detector_test.sv =====
// Top of the isolated pixel detector testbench: clock, reset, stimulus and verdict.
// Depends on ipd_pkg, the two channel interfaces, the block and isolated_pixel_checker.
module isolated_pixel_detector_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ipd_pkg::*;

    localparam int MAX_COLS     = 1024;
    localparam int MAX_ROWS     = 4096;
    // Pixels sent before the closing part, which adds about 1130 more.
    localparam int RANDOM_ITEMS = 420;
    // Cycles without any transaction before the run is declared hung.
    localparam int STALL_LIMIT  = 1000;

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  wr_en;
    ipd_cfg_index_t        wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    int pending_results;
    int error_count;
    int sent_count  = 0;
    int ready_hold  = 0;
    int stall_count = 0;
    bit idle_on;

    ipd_pixel_if  pixels();
    ipd_result_if results();

    isolated_pixel_detector #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixels   (pixels),
        .results  (results),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    isolated_pixel_checker #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) frame_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .pixels          (pixels),
        .results         (results),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .pending_results (pending_results),
        .error_count     (error_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: hold ready low in random bursts while idling is enabled.
    always @(posedge clk)
    begin
        if (!rst_n)
            results.ready <= 1'b0;
        else if (ready_hold > 0)
        begin
            ready_hold--;
            results.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            ready_hold = $urandom_range(1, 11) - 1;
            results.ready <= 1'b0;
        end
        else
            results.ready <= 1'b1;
    end

    // Watchdog: any transaction or register write resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (pixels.valid && pixels.ready) || (results.valid && results.ready)
            || wr_en)
            stall_count = 0;
        else
        begin
            stall_count++;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Zero acts as one, anything above the maximum acts as the maximum.
    function automatic int unsigned clamp_size(int unsigned value, int unsigned limit);
        if (value == 0)
            return 1;
        return (value > limit) ? limit : value;
    endfunction

    // Present one pixel and hold it until the block takes it; a random gap
    // may come first.
    task automatic send_pixel(bit value);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            pixels.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        pixels.valid <= 1'b1;
        pixels.pixel <= value;
        // Ready is settled at the falling edge; the transaction lands on the next rise.
        do @(negedge clk); while (!pixels.ready);
        @(posedge clk);
        sent_count++;
    endtask

    // Send the lowest n bits of a pattern, most significant bit first.
    task automatic send_bits(logic [15:0] bits, int n);
        for (int i = n - 1; i >= 0; i--)
            send_pixel(bits[i]);
    endtask

    // Send n pixels, each set with the given percent chance.
    task automatic send_frame(int unsigned n, int unsigned density);
        for (int i = 0; i < n; i++)
            send_pixel($urandom_range(0, 99) < density);
    endtask

    // Drop valid, wait for every outstanding frame verdict, then let the
    // pipeline settle. The first falling edge lets the checker count the
    // last transaction.
    task automatic drain_results(int extra);
        pixels.valid <= 1'b0;
        @(negedge clk);
        while (pending_results != 0)
            @(negedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // Write both size registers once the block is idle; each write restarts the frame.
    task automatic set_size(int unsigned rows, int unsigned cols);
        drain_results(4);
        wr_en    <= 1'b1;
        wr_index <= CFG_IMAGE_ROWS;
        wr_data  <= rows[CFG_DATA_W-1:0];
        @(posedge clk);
        wr_index <= CFG_IMAGE_COLS;
        wr_data  <= cols[CFG_DATA_W-1:0];
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    initial
    begin
        int unsigned rows;
        int unsigned cols;
        int unsigned frame_len;
        int unsigned density;
        int unsigned frames;

        pixels.valid  = 1'b0;
        pixels.pixel  = 1'b0;
        wr_en         = 1'b0;
        wr_index      = CFG_IMAGE_ROWS;
        wr_data       = '0;
        idle_on       = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset size is 1x1: every pixel is a frame of its own.
        send_bits(16'b10, 2);
        // Zero sizes act as one.
        set_size(0, 0);
        send_bits(16'b1, 1);
        // Single row: no up or down neighbors; the first pixel stands alone.
        set_size(1, 5);
        send_bits(16'b10110, 5);
        // Single column: no left or right neighbors.
        set_size(3, 1);
        send_bits(16'b010, 3);
        // Touching pixels only: nothing isolated.
        set_size(2, 2);
        send_bits(16'b1100, 4);
        // Lone center pixel in a 3x3 frame.
        set_size(3, 3);
        send_bits(16'b000010000, 9);

        // Random phases: small sizes, a few frames each, mixed densities so that
        // both verdicts show up. Some phases end mid-frame so the next write
        // restarts it.
        while (sent_count < RANDOM_ITEMS)
        begin
            idle_on <= ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0:       rows = 0;
                1:       rows = 1;
                2:       rows = $urandom_range(7, 12);
                default: rows = $urandom_range(2, 6);
            endcase
            case ($urandom_range(0, 9))
                0:       cols = 0;
                1:       cols = 1;
                2:       cols = $urandom_range(11, 40);
                default: cols = $urandom_range(2, 10);
            endcase
            set_size(rows, cols);
            frame_len = clamp_size(rows, MAX_ROWS) * clamp_size(cols, MAX_COLS);
            frames    = $urandom_range(1, 5);
            for (int f = 0; f <= frames && sent_count < RANDOM_ITEMS; f++)
            begin
                case ($urandom_range(0, 3))
                    0:       density = 0;
                    1:       density = $urandom_range(3, 20);
                    2:       density = $urandom_range(30, 60);
                    default: density = $urandom_range(80, 100);
                endcase
                if (f < frames)
                    send_frame(frame_len, density);
                else if (frame_len > 1 && $urandom_range(0, 5) == 0)
                    send_frame($urandom_range(1, frame_len - 1), density);
            end
        end

        // Closing part, with no idling on either side.
        idle_on <= 1'b0;
        // Oversize on both registers; the frame is left open and the next write
        // restarts it.
        set_size(8191, 2047);
        send_frame(40, 30);
        // Widest row, clamped to the maximum, as one sparse single-row frame.
        set_size(1, 2047);
        send_frame(MAX_COLS, 2);
        set_size(MAX_ROWS, MAX_COLS);
        send_frame(20, 50);
        // A few ordinary frames to finish.
        set_size(3, 4);
        send_frame(12, 0);
        send_frame(12, 10);
        send_frame(12, 50);
        send_frame(12, 100);

        drain_results(8);
        if (error_count == 0 && pending_results == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
sv/ipd_pkg.sv
sv/ipd_pixel_if.sv
sv/ipd_result_if.sv
sv/ipd_cell.sv
sv/ipd_line.sv
sv/isolated_pixel_detector.sv
tb/isolated_pixel_checker.sv
tb/isolated_pixel_detector_test.sv
